>>> design/mpmc_pkg.sv
// shared types and constants for the multi pattern match counter
// no dependencies
package mpmc_pkg;

  localparam int MAX_NODES   = 256;
  localparam int TOTAL_WIDTH = 32;

  localparam int NW = $clog2(MAX_NODES);      // node index width
  localparam int PW = $clog2(MAX_NODES + 1);  // node pointer width, holds the none code

  localparam logic [PW-1:0] NONE_PTR  = PW'(MAX_NODES);
  localparam logic [NW-1:0] ROOT_NODE = '0;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_PATTERN = 2'd1,
    ACT_BUILD   = 2'd2,
    ACT_TEXT    = 2'd3
  } action_e;

  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_SCAN  = 1'b1;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD_START,
    OP_SCAN_START,
    OP_BUILD_START,
    OP_RD_N,
    OP_FC,
    OP_RD_C,
    OP_NEXT,
    OP_RES_C,
    OP_RES_ROOT,
    OP_FOLLOW,
    OP_OVF,
    OP_LOAD_HIT,
    OP_ALLOC1,
    OP_ALLOC2,
    OP_RD_RES,
    OP_SCAN_ADD,
    OP_RD_HEAD,
    OP_BQ,
    OP_RD_P,
    OP_BP,
    OP_RD_BC,
    OP_BC,
    OP_BSET,
    OP_BDONE
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic c_none;
    logic n_root;
    logic hit;
    logic full;
    logic skip;
    logic last;
    logic head_lt_tail;
    logic bc_none;
    logic p_root;
    logic out_busy;
  } status_t;

endpackage

>>> design/multi_pattern_match_counter_core.sv
// multi pattern match counter: aho-corasick automaton over a node memory
// depends on mpmc_pkg, mpmc_ctrl and mpmc_dp
//
// usage
//   input channel: in_valid_i / in_stall_o carry one beat of action, symbol, last
//   actions: clear the node store, load a pattern byte, build failure links, scan
//   a text byte; a pattern or text ends on a beat with last set
//   output channel: out_valid_o / out_stall_i; a build gives one beat (kind 0,
//   total 0) and the last text byte gives one beat (kind 1, saturating total)
//   table_full_o reports that some pattern byte found no free node
// steps
//   clear and a skipped pattern byte are taken in the idle state
//   a pattern or text byte reads its node, walks the child list sibling by
//   sibling and, for text, follows failure links; it ends with a pattern hit,
//   node creation, the count read on a text hit, or a miss at the root
//   build takes each node off the queue and resolves the failure link of each
//   child, by the text-byte walk where the parent is not the root
// reset and stall
//   reset empties the node store (root only), zeroes the total and flag
//   a result waits in the output register while the receiver stalls; the next
//   beat is still taken and is held back only if it has a result of its own
module multi_pattern_match_counter_core import mpmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  symbol_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [31:0] match_total_o,
  output logic        table_full_o
);

  cmd_t    cmd;      // sequencer step for the datapath
  status_t status;   // compare and bound flags back to the sequencer

  // sequencer walks child lists, failure chains and the build queue
  mpmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_e'(action_i)),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // node memories, cursors, running total and result register
  mpmc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .symbol_i      (symbol_i),
    .last_i        (last_i),
    .out_stall_i   (out_stall_i),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .kind_o        (kind_o),
    .match_total_o (match_total_o),
    .table_full_o  (table_full_o)
  );

endmodule

>>> design/mpmc_ctrl.sv
// sequencer for the multi pattern match counter
// depends on mpmc_pkg; drives commands into mpmc_dp
module mpmc_ctrl import mpmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  action_e   action_i,
  input  status_t   status_i,
  output logic      in_stall_o,
  output cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_FC_RD, S_FC, S_SIB_RD, S_SIB, S_LHIT, S_ALLOC1, S_ALLOC2,
    S_MT_RD, S_MT, S_BQ_RD, S_BQ, S_BP_RD, S_BP, S_BC_RD, S_BC,
    S_BMT_RD, S_BMT, S_BDONE
  } state_e;

  typedef enum logic [1:0] {M_LOAD, M_SCAN, M_ADV} mode_e;

  state_e state_q, state_d, post;
  mode_e  mode_q, mode_d;

  always_comb begin
    case (mode_q)
      M_LOAD:  post = S_LHIT;
      M_SCAN:  post = S_MT_RD;
      default: post = S_BMT_RD;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    cmd_o.op   = OP_NOP;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (action_i)
            ACT_CLEAR: cmd_o.op = OP_CLEAR;
            ACT_PATTERN: begin
              cmd_o.op = OP_LOAD_START;
              if (!status_i.skip) begin
                state_d = S_FC_RD;
                mode_d  = M_LOAD;
              end
            end
            ACT_BUILD: begin
              cmd_o.op = OP_BUILD_START;
              state_d  = S_BQ_RD;
            end
            default: begin
              cmd_o.op = OP_SCAN_START;
              state_d  = S_FC_RD;
              mode_d   = M_SCAN;
            end
          endcase
        end
      end
      S_FC_RD: begin
        cmd_o.op = OP_RD_N;
        state_d  = S_FC;
      end
      S_FC: begin
        cmd_o.op = OP_FC;
        state_d  = S_SIB_RD;
      end
      S_SIB_RD: begin
        if (!status_i.c_none) begin
          cmd_o.op = OP_RD_C;
          state_d  = S_SIB;
        end else if (mode_q == M_LOAD) begin
          if (status_i.full) begin
            cmd_o.op = OP_OVF;
            state_d  = S_IDLE;
          end else begin
            state_d = S_ALLOC1;
          end
        end else if (status_i.n_root) begin
          cmd_o.op = OP_RES_ROOT;
          state_d  = post;
        end else begin
          cmd_o.op = OP_FOLLOW;
          state_d  = S_FC_RD;
        end
      end
      S_SIB: begin
        if (status_i.hit) begin
          cmd_o.op = OP_RES_C;
          state_d  = post;
        end else begin
          cmd_o.op = OP_NEXT;
          state_d  = S_SIB_RD;
        end
      end
      S_LHIT: begin
        cmd_o.op = OP_LOAD_HIT;
        state_d  = S_IDLE;
      end
      S_ALLOC1: begin
        cmd_o.op = OP_ALLOC1;
        state_d  = S_ALLOC2;
      end
      S_ALLOC2: begin
        cmd_o.op = OP_ALLOC2;
        state_d  = S_IDLE;
      end
      S_MT_RD: begin
        cmd_o.op = OP_RD_RES;
        state_d  = S_MT;
      end
      S_MT: begin
        if (!(status_i.last && status_i.out_busy)) begin
          cmd_o.op = OP_SCAN_ADD;
          state_d  = S_IDLE;
        end
      end
      S_BQ_RD: begin
        if (status_i.head_lt_tail) begin
          cmd_o.op = OP_RD_HEAD;
          state_d  = S_BQ;
        end else begin
          state_d = S_BDONE;
        end
      end
      S_BQ: begin
        cmd_o.op = OP_BQ;
        state_d  = S_BP_RD;
      end
      S_BP_RD: begin
        cmd_o.op = OP_RD_P;
        state_d  = S_BP;
      end
      S_BP: begin
        cmd_o.op = OP_BP;
        state_d  = S_BC_RD;
      end
      S_BC_RD: begin
        if (status_i.bc_none) begin
          state_d = S_BQ_RD;
        end else begin
          cmd_o.op = OP_RD_BC;
          state_d  = S_BC;
        end
      end
      S_BC: begin
        cmd_o.op = OP_BC;
        if (status_i.p_root) begin
          state_d = S_BMT_RD;
        end else begin
          state_d = S_FC_RD;
          mode_d  = M_ADV;
        end
      end
      S_BMT_RD: begin
        cmd_o.op = OP_RD_RES;
        state_d  = S_BMT;
      end
      S_BMT: begin
        cmd_o.op = OP_BSET;
        state_d  = S_BC_RD;
      end
      S_BDONE: begin
        if (!status_i.out_busy) begin
          cmd_o.op = OP_BDONE;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= M_LOAD;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

endmodule

>>> design/mpmc_dp.sv
// node memories, cursors, totals and the result register
// depends on mpmc_pkg; commanded by mpmc_ctrl
module mpmc_dp import mpmc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  input  logic [7:0]             symbol_i,
  input  logic                   last_i,
  input  logic                   out_stall_i,
  output status_t                status_o,
  output logic                   out_valid_o,
  output logic                   kind_o,
  output logic [31:0]            match_total_o,
  output logic                   table_full_o
);

  logic [7:0]    sym_mem  [MAX_NODES];
  logic [PW-1:0] fc_mem   [MAX_NODES];
  logic [PW-1:0] sib_mem  [MAX_NODES];
  logic [NW-1:0] fail_mem [MAX_NODES];
  logic          pend_mem [MAX_NODES];
  logic [PW-1:0] cnt_mem  [MAX_NODES];
  logic [NW-1:0] bq_mem   [MAX_NODES];

  logic [7:0]    rd_sym;
  logic [PW-1:0] rd_fc, rd_sib, rd_cnt;
  logic [NW-1:0] rd_fail, rd_bq;
  logic          rd_pend;

  logic [NW-1:0] raddr_q, raddr_d;

  // search and build registers
  logic [NW-1:0] sn_q, sfail_q, res_q, p_q, pfail_q;
  logic [PW-1:0] sc_q, fc0_q, bc_q, csib_q;
  logic [7:0]    key_q;
  logic          last_q, cpend_q;
  logic [PW-1:0] head_q, tail_q;

  // architectural state
  logic [PW-1:0]          nodes_used_q, root_fc_q;
  logic [NW-1:0]          lc_q, scan_q;
  logic [TOTAL_WIDTH-1:0] total_q;
  logic                   ovf_q, skip_q;

  logic                   out_valid_q, kind_q, full_q;
  logic [TOTAL_WIDTH-1:0] tot_q;

  logic [PW-1:0]          first_child, add;
  logic [TOTAL_WIDTH:0]   sum;
  logic [TOTAL_WIDTH-1:0] sat;

  // node write port
  logic [NW-1:0] waddr;
  logic          we_new, we_fc, we_pend, we_link, we_bq;
  logic [PW-1:0] fc_wdata;
  logic [NW-1:0] bq_waddr, bq_wdata;

  always_comb begin
    case (cmd_i.op)
      OP_RD_N:    raddr_d = sn_q;
      OP_RD_C:    raddr_d = sc_q[NW-1:0];
      OP_RD_RES:  raddr_d = res_q;
      OP_RD_HEAD: raddr_d = head_q[NW-1:0];
      OP_RD_P:    raddr_d = p_q;
      OP_RD_BC:   raddr_d = bc_q[NW-1:0];
      default:    raddr_d = raddr_q;
    endcase
  end

  assign first_child = (cmd_i.op == OP_BP) ? ((p_q == ROOT_NODE) ? root_fc_q : rd_fc)
                                           : ((sn_q == ROOT_NODE) ? root_fc_q : rd_fc);
  assign add = (res_q == ROOT_NODE) ? '0 : rd_cnt;
  assign sum = {1'b0, total_q} + (TOTAL_WIDTH+1)'(add);
  assign sat = sum[TOTAL_WIDTH] ? '1 : sum[TOTAL_WIDTH-1:0];

  always_comb begin
    waddr    = '0;
    we_new   = 1'b0;
    we_fc    = 1'b0;
    we_pend  = 1'b0;
    we_link  = 1'b0;
    we_bq    = 1'b0;
    fc_wdata = NONE_PTR;
    bq_waddr = '0;
    bq_wdata = ROOT_NODE;
    case (cmd_i.op)
      OP_ALLOC1: begin
        waddr  = nodes_used_q[NW-1:0];
        we_new = 1'b1;
        we_fc  = 1'b1;
      end
      OP_ALLOC2: begin
        waddr    = sn_q;
        we_fc    = (sn_q != ROOT_NODE);
        fc_wdata = PW'(res_q);
      end
      OP_LOAD_HIT: begin
        waddr   = res_q;
        we_pend = last_q;
      end
      OP_BSET: begin
        waddr    = bc_q[NW-1:0];
        we_link  = 1'b1;
        we_bq    = 1'b1;
        bq_waddr = tail_q[NW-1:0];
        bq_wdata = bc_q[NW-1:0];
      end
      OP_BUILD_START: we_bq = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_new) begin
      sym_mem[waddr] <= key_q;
      sib_mem[waddr] <= fc0_q;
    end
    if (we_fc) fc_mem[waddr] <= fc_wdata;
    if (we_new || we_pend) pend_mem[waddr] <= last_q;
    if (we_new) begin
      fail_mem[waddr] <= ROOT_NODE;
      cnt_mem[waddr]  <= '0;
    end else if (we_link) begin
      fail_mem[waddr] <= res_q;
      cnt_mem[waddr]  <= PW'(cpend_q) + add;
    end
    if (we_bq) bq_mem[bq_waddr] <= bq_wdata;
  end

  always_ff @(posedge clk_i) begin
    rd_sym  <= sym_mem[raddr_d];
    rd_fc   <= fc_mem[raddr_d];
    rd_sib  <= sib_mem[raddr_d];
    rd_fail <= fail_mem[raddr_d];
    rd_pend <= pend_mem[raddr_d];
    rd_cnt  <= cnt_mem[raddr_d];
    rd_bq   <= bq_mem[raddr_d];
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= raddr_d;
    case (cmd_i.op)
      OP_LOAD_START: begin
        sn_q   <= lc_q;
        key_q  <= symbol_i;
        last_q <= last_i;
      end
      OP_SCAN_START: begin
        sn_q   <= scan_q;
        key_q  <= symbol_i;
        last_q <= last_i;
      end
      OP_FC: begin
        sc_q    <= first_child;
        fc0_q   <= first_child;
        sfail_q <= rd_fail;
      end
      OP_NEXT:     sc_q  <= rd_sib;
      OP_RES_C:    res_q <= sc_q[NW-1:0];
      OP_RES_ROOT: res_q <= ROOT_NODE;
      OP_FOLLOW:   sn_q  <= sfail_q;
      OP_ALLOC1:   res_q <= nodes_used_q[NW-1:0];
      OP_BQ:       p_q   <= rd_bq;
      OP_BP: begin
        bc_q    <= first_child;
        pfail_q <= rd_fail;
      end
      OP_BC: begin
        key_q   <= rd_sym;
        csib_q  <= rd_sib;
        cpend_q <= rd_pend;
        sn_q    <= pfail_q;
        res_q   <= ROOT_NODE;
      end
      OP_BSET: bc_q <= csib_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_used_q <= PW'(1);
      root_fc_q    <= NONE_PTR;
      lc_q         <= ROOT_NODE;
      scan_q       <= ROOT_NODE;
      total_q      <= '0;
      ovf_q        <= 1'b0;
      skip_q       <= 1'b0;
      head_q       <= '0;
      tail_q       <= '0;
      out_valid_q  <= 1'b0;
      kind_q       <= KIND_BUILD;
      tot_q        <= '0;
      full_q       <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_CLEAR: begin
          nodes_used_q <= PW'(1);
          root_fc_q    <= NONE_PTR;
          lc_q         <= ROOT_NODE;
          scan_q       <= ROOT_NODE;
          total_q      <= '0;
          ovf_q        <= 1'b0;
          skip_q       <= 1'b0;
          head_q       <= '0;
          tail_q       <= '0;
        end
        OP_LOAD_START: begin
          if (skip_q && last_i) begin
            lc_q   <= ROOT_NODE;
            skip_q <= 1'b0;
          end
        end
        OP_OVF: begin
          ovf_q <= 1'b1;
          if (last_q) lc_q <= ROOT_NODE;
          else skip_q <= 1'b1;
        end
        OP_LOAD_HIT: lc_q <= last_q ? ROOT_NODE : res_q;
        OP_ALLOC1:   nodes_used_q <= nodes_used_q + PW'(1);
        OP_ALLOC2: begin
          if (sn_q == ROOT_NODE) root_fc_q <= PW'(res_q);
          lc_q <= last_q ? ROOT_NODE : res_q;
        end
        OP_SCAN_ADD: begin
          if (last_q) begin
            total_q     <= '0;
            scan_q      <= ROOT_NODE;
            out_valid_q <= 1'b1;
            kind_q      <= KIND_SCAN;
            tot_q       <= sat;
            full_q      <= ovf_q;
          end else begin
            total_q <= sat;
            scan_q  <= res_q;
          end
        end
        OP_BUILD_START: begin
          head_q <= '0;
          tail_q <= PW'(1);
        end
        OP_RD_HEAD: head_q <= head_q + PW'(1);
        OP_BSET:    tail_q <= tail_q + PW'(1);
        OP_BDONE: begin
          total_q     <= '0;
          scan_q      <= ROOT_NODE;
          out_valid_q <= 1'b1;
          kind_q      <= KIND_BUILD;
          tot_q       <= '0;
          full_q      <= ovf_q;
        end
        default: ;
      endcase
    end
  end

  assign status_o.c_none       = (sc_q == NONE_PTR);
  assign status_o.n_root       = (sn_q == ROOT_NODE);
  assign status_o.hit          = (rd_sym == key_q);
  assign status_o.full         = (nodes_used_q == PW'(MAX_NODES));
  assign status_o.skip         = skip_q;
  assign status_o.last         = last_q;
  assign status_o.head_lt_tail = (head_q < tail_q);
  assign status_o.bc_none      = (bc_q == NONE_PTR);
  assign status_o.p_root       = (p_q == ROOT_NODE);
  assign status_o.out_busy     = out_valid_q && out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign match_total_o = 32'(tot_q);
  assign table_full_o  = full_q;

  a_nodes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nodes_used_q != '0) && (nodes_used_q <= PW'(MAX_NODES)))
    else $error("node count out of range");

  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= tail_q) && (tail_q <= nodes_used_q))
    else $error("build queue head passed tail");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(cmd_i.op) == OP_SCAN_ADD || $past(cmd_i.op) == OP_BDONE))
    else $error("result raised without a result command");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> (cmd_i.op != OP_SCAN_ADD || !last_q) && cmd_i.op != OP_BDONE)
    else $error("result register overwritten while held");

endmodule
